@@ src/pts_pkg.sv @@
// Shared widths, types and constants of the point to triangle squared distance block.
`timescale 1ns / 1ps
`default_nettype none
package pts_pkg;
  localparam int COORD_W = 32;
  localparam int DIFF_W = COORD_W + 2;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int WW = 144;
  localparam int FRAC = 32;
  localparam int Q_W = FRAC + 2;
  localparam int DIV_ST = FRAC + 1;
  localparam int OUT_W = 64;
  localparam int N_COORD = 12;
  localparam int GRAM_W = 68;
  localparam int I_W = 102;
  localparam int MUL_LW = 34;

  typedef logic signed [WW-1:0] wide_t;

  typedef enum logic [2:0] {
    MODE_FIXED,
    MODE_EDGE,
    MODE_QUAD_INT,
    MODE_QUAD_S,
    MODE_QUAD_T
  } mode_t;

  typedef struct packed {
    wide_t k00;
    wide_t k01;
    wide_t k11;
    wide_t h0;
    wide_t h1;
    wide_t cq;
  } gram_t;

  typedef struct packed {
    mode_t mode;
    wide_t fixv;
    wide_t h;
    gram_t g;
  } side_t;

  typedef struct packed {
    side_t side;
    wide_t num_a;
    wide_t den_a;
    wide_t num_b;
    wide_t den_b;
  } job_t;

  localparam wide_t ONE_Q = wide_t'(1) << FRAC;
endpackage
`default_nettype wire

@@ src/pts_gram.sv @@
// Edge vectors and Gram dot products over three register stages.
`timescale 1ns / 1ps
`default_nettype none
module pts_gram #(
  parameter int COORD_WIDTH = pts_pkg::COORD_W
) (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic valid_i,
  input  logic [pts_pkg::N_COORD-1:0][pts_pkg::COORD_W-1:0] coord_i,
  output logic valid_o,
  output pts_pkg::gram_t gram_o
);
  typedef logic signed [pts_pkg::DIFF_W-1:0] diff_t;
  typedef logic signed [pts_pkg::PROD_W-1:0] prod_t;

  diff_t c_nxt [pts_pkg::N_COORD];
  diff_t ea_r [3];
  diff_t eb_r [3];
  diff_t dv_r [3];
  prod_t pr_r [18];
  pts_pkg::gram_t gram_r;
  logic [2:0] v_r;

  always_comb begin
    for (int i = 0; i < pts_pkg::N_COORD; i++) begin
      c_nxt[i] = diff_t'(signed'(coord_i[i][COORD_WIDTH-1:0]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[1:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ea_r[i] <= c_nxt[3 + i] - c_nxt[i];
        eb_r[i] <= c_nxt[6 + i] - c_nxt[i];
        dv_r[i] <= c_nxt[i] - c_nxt[9 + i];
        pr_r[i]      <= ea_r[i] * ea_r[i];
        pr_r[3 + i]  <= ea_r[i] * eb_r[i];
        pr_r[6 + i]  <= eb_r[i] * eb_r[i];
        pr_r[9 + i]  <= dv_r[i] * ea_r[i];
        pr_r[12 + i] <= dv_r[i] * eb_r[i];
        pr_r[15 + i] <= dv_r[i] * dv_r[i];
      end
      gram_r.k00 <= pts_pkg::wide_t'(pr_r[0]) + pts_pkg::wide_t'(pr_r[1])
                  + pts_pkg::wide_t'(pr_r[2]);
      gram_r.k01 <= pts_pkg::wide_t'(pr_r[3]) + pts_pkg::wide_t'(pr_r[4])
                  + pts_pkg::wide_t'(pr_r[5]);
      gram_r.k11 <= pts_pkg::wide_t'(pr_r[6]) + pts_pkg::wide_t'(pr_r[7])
                  + pts_pkg::wide_t'(pr_r[8]);
      gram_r.h0  <= pts_pkg::wide_t'(pr_r[9]) + pts_pkg::wide_t'(pr_r[10])
                  + pts_pkg::wide_t'(pr_r[11]);
      gram_r.h1  <= pts_pkg::wide_t'(pr_r[12]) + pts_pkg::wide_t'(pr_r[13])
                  + pts_pkg::wide_t'(pr_r[14]);
      gram_r.cq  <= pts_pkg::wide_t'(pr_r[15]) + pts_pkg::wide_t'(pr_r[16])
                  + pts_pkg::wide_t'(pr_r[17]);
    end
  end

  assign valid_o = v_r[2];
  assign gram_o = gram_r;
endmodule
`default_nettype wire

@@ src/pts_solve.sv @@
// Determinant, unnormalized parameters and region classification over four stages.
`timescale 1ns / 1ps
`default_nettype none
module pts_solve (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic valid_i,
  input  pts_pkg::gram_t gram_i,
  output logic valid_o,
  output pts_pkg::job_t job_o
);
  localparam int MSB = pts_pkg::WW - 1;
  localparam int GW = pts_pkg::GRAM_W;

  pts_pkg::wide_t a_p, b_p, c_p, d_p, e_p, f_p, vtx0_r, vtx1_r, opp_r;
  pts_pkg::gram_t g3_r, g4_r, g5_r;
  pts_pkg::wide_t gd_r, us_r, ut_r, vtx0b_r, vtx1b_r, oppb_r;
  pts_pkg::wide_t x01h0_r, x11h1_r, x01h1_r, x00h0_r;
  pts_pkg::wide_t gd_nxt;
  pts_pkg::job_t job_nxt, job_r;
  logic [3:0] v_r;
  logic use_e0, use_e1;
  pts_pkg::wide_t nu;

  pts_mul u_mul_a (
    .clk(clk), .en(en), .a_i(gram_i.k00[GW-1:0]), .b_i(gram_i.k11[GW-1:0]), .p_o(a_p)
  );
  pts_mul u_mul_b (
    .clk(clk), .en(en), .a_i(gram_i.k01[GW-1:0]), .b_i(gram_i.k01[GW-1:0]), .p_o(b_p)
  );
  pts_mul u_mul_c (
    .clk(clk), .en(en), .a_i(gram_i.k01[GW-1:0]), .b_i(gram_i.h1[GW-1:0]), .p_o(c_p)
  );
  pts_mul u_mul_d (
    .clk(clk), .en(en), .a_i(gram_i.k11[GW-1:0]), .b_i(gram_i.h0[GW-1:0]), .p_o(d_p)
  );
  pts_mul u_mul_e (
    .clk(clk), .en(en), .a_i(gram_i.k01[GW-1:0]), .b_i(gram_i.h0[GW-1:0]), .p_o(e_p)
  );
  pts_mul u_mul_f (
    .clk(clk), .en(en), .a_i(gram_i.k00[GW-1:0]), .b_i(gram_i.h1[GW-1:0]), .p_o(f_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[2:0], valid_i};
    end
  end

  assign gd_nxt = a_p - b_p;

  always_ff @(posedge clk) begin
    if (en) begin
      g3_r <= gram_i;
      vtx0_r <= g3_r.k00 + (g3_r.h0 <<< 1) + g3_r.cq;
      vtx1_r <= g3_r.k11 + (g3_r.h1 <<< 1) + g3_r.cq;
      opp_r <= g3_r.k00 - (g3_r.k01 <<< 1) + g3_r.k11;
      g4_r <= g3_r;
      gd_r <= gd_nxt[MSB] ? -gd_nxt : gd_nxt;
      us_r <= c_p - d_p;
      ut_r <= e_p - f_p;
      x01h0_r <= g4_r.k01 + g4_r.h0;
      x11h1_r <= g4_r.k11 + g4_r.h1;
      x01h1_r <= g4_r.k01 + g4_r.h1;
      x00h0_r <= g4_r.k00 + g4_r.h0;
      vtx0b_r <= vtx0_r;
      vtx1b_r <= vtx1_r;
      oppb_r <= opp_r;
      g5_r <= g4_r;
      job_r <= job_nxt;
    end
  end

  always_comb begin
    job_nxt = '0;
    job_nxt.side.g = g5_r;
    job_nxt.side.mode = pts_pkg::MODE_FIXED;
    use_e0 = 1'b0;
    use_e1 = 1'b0;
    nu = '0;
    if ((us_r + ut_r) <= gd_r) begin
      if (us_r[MSB]) begin
        if (ut_r[MSB] && g5_r.h0[MSB]) begin
          use_e0 = 1'b1;
        end else begin
          use_e1 = 1'b1;
        end
      end else if (ut_r[MSB]) begin
        use_e0 = 1'b1;
      end else begin
        job_nxt.side.mode = pts_pkg::MODE_QUAD_INT;
        job_nxt.num_a = us_r;
        job_nxt.den_a = gd_r;
        job_nxt.num_b = ut_r;
        job_nxt.den_b = gd_r;
      end
    end else if (us_r[MSB]) begin
      if (x11h1_r > x01h0_r) begin
        nu = x11h1_r - x01h0_r;
        if (nu >= oppb_r) begin
          job_nxt.side.fixv = vtx0b_r;
        end else begin
          job_nxt.side.mode = pts_pkg::MODE_QUAD_S;
          job_nxt.num_a = nu;
          job_nxt.den_a = oppb_r;
        end
      end else begin
        use_e1 = 1'b1;
      end
    end else if (ut_r[MSB]) begin
      if (x00h0_r > x01h1_r) begin
        nu = x00h0_r - x01h1_r;
        if (nu >= oppb_r) begin
          job_nxt.side.fixv = vtx1b_r;
        end else begin
          job_nxt.side.mode = pts_pkg::MODE_QUAD_T;
          job_nxt.num_a = nu;
          job_nxt.den_a = oppb_r;
        end
      end else begin
        use_e0 = 1'b1;
      end
    end else begin
      nu = x11h1_r - x01h0_r;
      if (nu[MSB] || nu == '0) begin
        job_nxt.side.fixv = vtx1b_r;
      end else if (nu >= oppb_r) begin
        job_nxt.side.fixv = vtx0b_r;
      end else begin
        job_nxt.side.mode = pts_pkg::MODE_QUAD_S;
        job_nxt.num_a = nu;
        job_nxt.den_a = oppb_r;
      end
    end
    if (use_e0) begin
      if (!g5_r.h0[MSB]) begin
        job_nxt.side.fixv = g5_r.cq;
      end else if (-g5_r.h0 >= g5_r.k00) begin
        job_nxt.side.fixv = vtx0b_r;
      end else begin
        job_nxt.side.mode = pts_pkg::MODE_EDGE;
        job_nxt.side.h = g5_r.h0;
        job_nxt.num_a = -g5_r.h0;
        job_nxt.den_a = g5_r.k00;
      end
    end
    if (use_e1) begin
      if (!g5_r.h1[MSB]) begin
        job_nxt.side.fixv = g5_r.cq;
      end else if (-g5_r.h1 >= g5_r.k11) begin
        job_nxt.side.fixv = vtx1b_r;
      end else begin
        job_nxt.side.mode = pts_pkg::MODE_EDGE;
        job_nxt.side.h = g5_r.h1;
        job_nxt.num_a = -g5_r.h1;
        job_nxt.den_a = g5_r.k11;
      end
    end
  end

  assign valid_o = v_r[3];
  assign job_o = job_r;
endmodule
`default_nettype wire

@@ src/pts_div.sv @@
// Pipelined restoring divider for floor(num * 2^32 / den) and a two-stage limb multiplier.
`timescale 1ns / 1ps
`default_nettype none
module pts_div (
  input  logic clk,
  input  logic en,
  input  pts_pkg::wide_t num_i,
  input  pts_pkg::wide_t den_i,
  output logic [pts_pkg::FRAC:0] q_o,
  output logic deg_o
);
  localparam int RW = pts_pkg::WW + 1;
  localparam int NST = pts_pkg::DIV_ST;

  logic [RW-1:0] rem_r [NST];
  logic [RW-1:0] den_r [NST];
  logic [pts_pkg::FRAC:0] q_r [NST];
  logic deg_r [NST];
  logic zero_r [NST];
  logic [RW-1:0] num_u, den_u;
  logic bit0;

  assign num_u = RW'(unsigned'(num_i));
  assign den_u = RW'(unsigned'(den_i));
  assign bit0 = num_u >= den_u;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= bit0 ? num_u - den_u : num_u;
      den_r[0] <= den_u;
      q_r[0] <= {{pts_pkg::FRAC{1'b0}}, bit0};
      deg_r[0] <= den_i[pts_pkg::WW-1] || den_i == '0;
      zero_r[0] <= num_i[pts_pkg::WW-1];
    end
  end

  for (genvar i = 1; i < NST; i++) begin : g_st
    logic [RW-1:0] sh;
    logic b;
    assign sh = {rem_r[i-1][RW-2:0], 1'b0};
    assign b = sh >= den_r[i-1];
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i] <= b ? sh - den_r[i-1] : sh;
        den_r[i] <= den_r[i-1];
        q_r[i] <= {q_r[i-1][pts_pkg::FRAC-1:0], b};
        deg_r[i] <= deg_r[i-1];
        zero_r[i] <= zero_r[i-1];
      end
    end
  end

  assign q_o = (zero_r[NST-1] || deg_r[NST-1]) ? '0 : q_r[NST-1];
  assign deg_o = deg_r[NST-1];
endmodule

// The operands are cut into limbs; the limb products are registered, then summed.
module pts_mul #(
  parameter int AW = pts_pkg::GRAM_W,
  parameter int BW = pts_pkg::GRAM_W
) (
  input  logic clk,
  input  logic en,
  input  logic signed [AW-1:0] a_i,
  input  logic signed [BW-1:0] b_i,
  output pts_pkg::wide_t p_o
);
  localparam int LW = pts_pkg::MUL_LW;
  localparam int NA = (AW + LW - 1) / LW;
  localparam int NB = (BW + LW - 1) / LW;

  typedef logic signed [LW:0] limb_t;
  typedef logic signed [2*LW+1:0] part_t;

  logic signed [NA*LW-1:0] a_x;
  logic signed [NB*LW-1:0] b_x;
  limb_t al [NA];
  limb_t bl [NB];
  part_t pp_r [NA][NB];
  pts_pkg::wide_t sum, p_r;

  assign a_x = (NA*LW)'(a_i);
  assign b_x = (NB*LW)'(b_i);

  always_comb begin
    for (int i = 0; i < NA; i++) begin
      al[i] = {(i == NA - 1) && a_x[i*LW+LW-1], a_x[i*LW +: LW]};
    end
    for (int j = 0; j < NB; j++) begin
      bl[j] = {(j == NB - 1) && b_x[j*LW+LW-1], b_x[j*LW +: LW]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i][j] <= al[i] * bl[j];
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (pts_pkg::wide_t'(pp_r[i][j]) <<< (LW * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum;
    end
  end

  assign p_o = p_r;
endmodule
`default_nettype wire

@@ src/pts_eval.sv @@
// Quadratic and edge distance evaluation, result clamp and output register.
`timescale 1ns / 1ps
`default_nettype none
module pts_eval (
  input  logic clk,
  input  logic rst_n,
  input  logic en,
  input  logic valid_i,
  input  pts_pkg::side_t side_i,
  input  logic [pts_pkg::FRAC:0] qa_i,
  input  logic [pts_pkg::FRAC:0] qb_i,
  input  logic dega_i,
  input  logic degb_i,
  output logic valid_o,
  output logic [pts_pkg::OUT_W-1:0] dist_o,
  output logic sat_o,
  output logic deg_o
);
  typedef logic signed [pts_pkg::Q_W-1:0] q_t;
  localparam int MSB = pts_pkg::WW - 1;
  localparam int GW = pts_pkg::GRAM_W;
  localparam int IW = pts_pkg::I_W;

  q_t qa, qs_nxt, qt_nxt;
  q_t qs0_r, qt0_r, qs1_r, qt1_r, qs2_r, qt2_r;
  pts_pkg::side_t s0_r, s1_r, s2_r, s2b_r, s3_r;
  pts_pkg::wide_t pa_p, pb_p, pc_p, pd_p, pe_p, t1_p, t2_p;
  pts_pkg::wide_t i1_r, i2_r, ed2_r, ed2b_r, ed3_r, dist_r, quad;
  logic deg0_r, deg1_r, deg2_r, deg2b_r, deg3_r, deg4_r, deg_nxt;
  logic [6:0] v_r;
  logic [pts_pkg::OUT_W-1:0] dist_out_r;
  logic sat_r, degf_r;

  assign qa = q_t'(qa_i);

  always_comb begin
    qs_nxt = qa;
    qt_nxt = q_t'(qb_i);
    case (side_i.mode)
      pts_pkg::MODE_QUAD_S: begin
        qt_nxt = q_t'(pts_pkg::ONE_Q) - qa;
      end
      pts_pkg::MODE_QUAD_T: begin
        qt_nxt = qa;
        qs_nxt = q_t'(pts_pkg::ONE_Q) - qa;
      end
      default: begin
      end
    endcase
    deg_nxt = (side_i.mode != pts_pkg::MODE_FIXED && dega_i)
           || (side_i.mode == pts_pkg::MODE_QUAD_INT && degb_i);
  end

  pts_mul #(.AW(GW), .BW(pts_pkg::Q_W)) u_mul_pa (
    .clk(clk), .en(en), .a_i(side_i.g.k00[GW-1:0]), .b_i(qs_nxt), .p_o(pa_p)
  );
  pts_mul #(.AW(GW), .BW(pts_pkg::Q_W)) u_mul_pb (
    .clk(clk), .en(en), .a_i(side_i.g.k01[GW-1:0]), .b_i(qt_nxt), .p_o(pb_p)
  );
  pts_mul #(.AW(GW), .BW(pts_pkg::Q_W)) u_mul_pc (
    .clk(clk), .en(en), .a_i(side_i.g.k01[GW-1:0]), .b_i(qs_nxt), .p_o(pc_p)
  );
  pts_mul #(.AW(GW), .BW(pts_pkg::Q_W)) u_mul_pd (
    .clk(clk), .en(en), .a_i(side_i.g.k11[GW-1:0]), .b_i(qt_nxt), .p_o(pd_p)
  );
  pts_mul #(.AW(GW), .BW(pts_pkg::Q_W)) u_mul_pe (
    .clk(clk), .en(en), .a_i(side_i.h[GW-1:0]), .b_i(qa), .p_o(pe_p)
  );
  pts_mul #(.AW(IW), .BW(pts_pkg::Q_W)) u_mul_t1 (
    .clk(clk), .en(en), .a_i(i1_r[IW-1:0]), .b_i(qs2_r), .p_o(t1_p)
  );
  pts_mul #(.AW(IW), .BW(pts_pkg::Q_W)) u_mul_t2 (
    .clk(clk), .en(en), .a_i(i2_r[IW-1:0]), .b_i(qt2_r), .p_o(t2_p)
  );

  assign quad = ((t1_p + t2_p) >>> (2 * pts_pkg::FRAC)) + s3_r.g.cq;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[5:0], valid_i};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      qs0_r <= qs_nxt;
      qt0_r <= qt_nxt;
      s0_r <= side_i;
      deg0_r <= deg_nxt;

      qs1_r <= qs0_r;
      qt1_r <= qt0_r;
      s1_r <= s0_r;
      deg1_r <= deg0_r;

      i1_r <= pa_p + pb_p + (s1_r.g.h0 <<< (pts_pkg::FRAC + 1));
      i2_r <= pc_p + pd_p + (s1_r.g.h1 <<< (pts_pkg::FRAC + 1));
      ed2_r <= (pe_p >>> pts_pkg::FRAC) + s1_r.g.cq;
      qs2_r <= qs1_r;
      qt2_r <= qt1_r;
      s2_r <= s1_r;
      deg2_r <= deg1_r;

      ed2b_r <= ed2_r;
      s2b_r <= s2_r;
      deg2b_r <= deg2_r;

      ed3_r <= ed2b_r;
      s3_r <= s2b_r;
      deg3_r <= deg2b_r;

      case (s3_r.mode)
        pts_pkg::MODE_FIXED: dist_r <= s3_r.fixv;
        pts_pkg::MODE_EDGE:  dist_r <= ed3_r;
        default:             dist_r <= quad;
      endcase
      deg4_r <= deg3_r;

      if (deg4_r) begin
        dist_out_r <= '1;
        sat_r <= 1'b0;
        degf_r <= 1'b1;
      end else if (dist_r[MSB]) begin
        dist_out_r <= '0;
        sat_r <= 1'b0;
        degf_r <= 1'b0;
      end else if (dist_r[MSB:pts_pkg::OUT_W] != '0) begin
        dist_out_r <= '1;
        sat_r <= 1'b1;
        degf_r <= 1'b0;
      end else begin
        dist_out_r <= dist_r[pts_pkg::OUT_W-1:0];
        sat_r <= 1'b0;
        degf_r <= 1'b0;
      end
    end
  end

  assign valid_o = v_r[6];
  assign dist_o = dist_out_r;
  assign sat_o = sat_r;
  assign deg_o = degf_r;
endmodule
`default_nettype wire

@@ src/point_triangle_sq_distance_top.sv @@
// Top level of the pipelined point to closed triangle squared distance block.
//
//   channel | direction | handshake          | word
//   in_     | input     | in_valid/in_stall   | three vertices and a point, Q16.16
//   out_    | output    | out_valid/out_stall | squared distance Q32.32 and two flags
//
// A word is accepted every cycle while the output is not stalled.
// Each word passes the Gram, solve, quotient divider (33 restoring stages) and evaluation stages.
// Reset clears only the valid bits of the stages.
// A stalled output freezes the whole pipeline, so nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none
module point_triangle_sq_distance_top #(
  parameter int COORD_WIDTH = pts_pkg::COORD_W
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  input  logic signed [31:0] in_v0_x,
  input  logic signed [31:0] in_v0_y,
  input  logic signed [31:0] in_v0_z,
  input  logic signed [31:0] in_v1_x,
  input  logic signed [31:0] in_v1_y,
  input  logic signed [31:0] in_v1_z,
  input  logic signed [31:0] in_v2_x,
  input  logic signed [31:0] in_v2_y,
  input  logic signed [31:0] in_v2_z,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  output logic out_valid,
  input  logic out_stall,
  output logic [63:0] out_sq_distance,
  output logic out_saturated,
  output logic out_degenerate
);
  localparam int NST = pts_pkg::DIV_ST;

  logic en;
  logic [pts_pkg::N_COORD-1:0][pts_pkg::COORD_W-1:0] coords;
  logic gram_v, job_v;
  pts_pkg::gram_t gram;
  pts_pkg::job_t job;
  pts_pkg::side_t sd_r [NST];
  logic v_dr [NST];
  logic [pts_pkg::FRAC:0] qa, qb;
  logic dega, degb;

  assign en = !out_valid || !out_stall;
  assign in_stall = !en;

  assign coords = {in_point_z, in_point_y, in_point_x, in_v2_z, in_v2_y, in_v2_x,
                   in_v1_z, in_v1_y, in_v1_x, in_v0_z, in_v0_y, in_v0_x};

  pts_gram #(.COORD_WIDTH(COORD_WIDTH)) u_gram (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(in_valid), .coord_i(coords),
    .valid_o(gram_v), .gram_o(gram)
  );

  pts_solve u_solve (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(gram_v), .gram_i(gram),
    .valid_o(job_v), .job_o(job)
  );

  pts_div u_div_a (
    .clk(clk), .en(en), .num_i(job.num_a), .den_i(job.den_a), .q_o(qa), .deg_o(dega)
  );

  pts_div u_div_b (
    .clk(clk), .en(en), .num_i(job.num_b), .den_i(job.den_b), .q_o(qb), .deg_o(degb)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_dr[0] <= 1'b0;
    end else if (en) begin
      v_dr[0] <= job_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd_r[0] <= job.side;
    end
  end

  for (genvar i = 1; i < NST; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_dr[i] <= 1'b0;
      end else if (en) begin
        v_dr[i] <= v_dr[i-1];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        sd_r[i] <= sd_r[i-1];
      end
    end
  end

  pts_eval u_eval (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(v_dr[NST-1]), .side_i(sd_r[NST-1]),
    .qa_i(qa), .qb_i(qb), .dega_i(dega), .degb_i(degb),
    .valid_o(out_valid), .dist_o(out_sq_distance), .sat_o(out_saturated),
    .deg_o(out_degenerate)
  );

  a_deg_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_sq_distance == '1 && !out_saturated)
    else $error("degenerate word without maximum distance");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_sq_distance == '1)
    else $error("saturated word without maximum distance");

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Self-checking testbench for the point to triangle squared distance block.
`timescale 1ns / 1ps
module tb;
  typedef logic signed [255:0] big_t;

  typedef struct {
    logic signed [31:0] c[12];
    bit wait_empty;
  } query_t;

  typedef struct {
    logic [63:0] sq_distance;
    logic saturated;
    logic degenerate;
  } dist_t;

  localparam big_t MAX_Q = (big_t'(1) << 64) - 1;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] in_c[12] = '{default: 32'sd0};
  logic out_valid;
  logic out_stall = 1'b0;
  logic [63:0] out_sq_distance;
  logic out_saturated;
  logic out_degenerate;

  query_t pending_queries[$];
  dist_t expected_dists[$];
  bit took = 1'b0;
  bit all_queued = 1'b0;
  int n_sent = 0;
  int n_errors = 0;

  point_triangle_sq_distance_top dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_v0_x(in_c[0]), .in_v0_y(in_c[1]), .in_v0_z(in_c[2]),
    .in_v1_x(in_c[3]), .in_v1_y(in_c[4]), .in_v1_z(in_c[5]),
    .in_v2_x(in_c[6]), .in_v2_y(in_c[7]), .in_v2_z(in_c[8]),
    .in_point_x(in_c[9]), .in_point_y(in_c[10]), .in_point_z(in_c[11]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_sq_distance(out_sq_distance), .out_saturated(out_saturated),
    .out_degenerate(out_degenerate)
  );

  always #5 clk = ~clk;

  function automatic big_t ratio_q32(big_t num, big_t den, inout bit deg);
    logic [255:0] n;
    logic [255:0] d;
    if (den <= 0) begin
      deg = 1'b1;
      return 0;
    end
    if (num < 0) return 0;
    n = num;
    d = den;
    n = n << 32;
    return big_t'(n / d);
  endfunction

  function automatic big_t quad_dist(big_t k00, big_t k01, big_t k11, big_t h0, big_t h1,
                                     big_t cq, big_t qs, big_t qt);
    big_t i1;
    big_t i2;
    big_t tot;
    i1 = k00 * qs + k01 * qt + ((2 * h0) <<< 32);
    i2 = k01 * qs + k11 * qt + ((2 * h1) <<< 32);
    tot = qs * i1 + qt * i2;
    return (tot >>> 64) + cq;
  endfunction

  function automatic big_t edge_dist(big_t h, big_t k, big_t cq, big_t vtx, inout bit deg);
    big_t q;
    if (h >= 0) return cq;
    if (-h >= k) return vtx;
    q = ratio_q32(-h, k, deg);
    return ((h * q) >>> 32) + cq;
  endfunction

  function automatic dist_t predict_dist(query_t q);
    big_t v0[3], e0[3], e1[3], d[3];
    big_t k00, k01, k11, h0, h1, cq, gd, us, ut, vtx0, vtx1, opp, sq_dist, x0, x1, nu, qs, qt;
    big_t one;
    bit deg;
    dist_t r;
    deg = 1'b0;
    one = big_t'(1) << 32;
    for (int i = 0; i < 3; i++) begin
      v0[i] = q.c[i];
      e0[i] = big_t'(q.c[3 + i]) - v0[i];
      e1[i] = big_t'(q.c[6 + i]) - v0[i];
      d[i] = v0[i] - big_t'(q.c[9 + i]);
    end
    k00 = e0[0] * e0[0] + e0[1] * e0[1] + e0[2] * e0[2];
    k01 = e0[0] * e1[0] + e0[1] * e1[1] + e0[2] * e1[2];
    k11 = e1[0] * e1[0] + e1[1] * e1[1] + e1[2] * e1[2];
    h0 = d[0] * e0[0] + d[1] * e0[1] + d[2] * e0[2];
    h1 = d[0] * e1[0] + d[1] * e1[1] + d[2] * e1[2];
    cq = d[0] * d[0] + d[1] * d[1] + d[2] * d[2];
    gd = k00 * k11 - k01 * k01;
    if (gd < 0) gd = -gd;
    us = k01 * h1 - k11 * h0;
    ut = k01 * h0 - k00 * h1;
    vtx0 = k00 + 2 * h0 + cq;
    vtx1 = k11 + 2 * h1 + cq;
    opp = k00 - 2 * k01 + k11;
    if (us + ut <= gd) begin
      if (us < 0) begin
        if (ut < 0 && h0 < 0) sq_dist = edge_dist(h0, k00, cq, vtx0, deg);
        else sq_dist = edge_dist(h1, k11, cq, vtx1, deg);
      end else if (ut < 0) begin
        sq_dist = edge_dist(h0, k00, cq, vtx0, deg);
      end else begin
        qs = ratio_q32(us, gd, deg);
        qt = ratio_q32(ut, gd, deg);
        sq_dist = quad_dist(k00, k01, k11, h0, h1, cq, qs, qt);
      end
    end else if (us < 0) begin
      x0 = k01 + h0;
      x1 = k11 + h1;
      if (x1 > x0) begin
        nu = x1 - x0;
        if (nu >= opp) sq_dist = vtx0;
        else begin
          qs = ratio_q32(nu, opp, deg);
          sq_dist = quad_dist(k00, k01, k11, h0, h1, cq, qs, one - qs);
        end
      end else sq_dist = edge_dist(h1, k11, cq, vtx1, deg);
    end else if (ut < 0) begin
      x0 = k01 + h1;
      x1 = k00 + h0;
      if (x1 > x0) begin
        nu = x1 - x0;
        if (nu >= opp) sq_dist = vtx1;
        else begin
          qt = ratio_q32(nu, opp, deg);
          sq_dist = quad_dist(k00, k01, k11, h0, h1, cq, one - qt, qt);
        end
      end else sq_dist = edge_dist(h0, k00, cq, vtx0, deg);
    end else begin
      nu = (k11 + h1) - (k01 + h0);
      if (nu <= 0) sq_dist = vtx1;
      else if (nu >= opp) sq_dist = vtx0;
      else begin
        qs = ratio_q32(nu, opp, deg);
        sq_dist = quad_dist(k00, k01, k11, h0, h1, cq, qs, one - qs);
      end
    end
    r.saturated = 1'b0;
    r.degenerate = 1'b0;
    if (deg) begin
      r.sq_distance = '1;
      r.degenerate = 1'b1;
    end else if (sq_dist < 0) begin
      r.sq_distance = '0;
    end else if (sq_dist > MAX_Q) begin
      r.sq_distance = '1;
      r.saturated = 1'b1;
    end else begin
      r.sq_distance = sq_dist[63:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    n_errors++;
  endtask

  function automatic int phase_now();
    return (n_sent / 100) % 4;
  endfunction

  always @(negedge clk) begin
    int ph;
    bit idle;
    bit stall;
    ph = phase_now();
    idle = (ph == 1) ? ($urandom_range(99) < 75) : (ph == 3) ? ($urandom_range(99) < 10) : 1'b0;
    stall = (ph == 2) ? ($urandom_range(99) < 75) : (ph == 3) ? ($urandom_range(99) < 10) : 1'b0;
    if (rst_n) out_stall <= stall;
    if (rst_n && (!in_valid || took)) begin
      if (pending_queries.size() > 0 && !idle &&
          (!pending_queries[0].wait_empty || expected_dists.size() == 0)) begin
        query_t q;
        q = pending_queries.pop_front();
        in_c <= q.c;
        in_valid <= 1'b1;
        n_sent++;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    query_t q;
    dist_t e;
    took <= in_valid && !in_stall && rst_n;
    if (rst_n && in_valid && !in_stall) begin
      q.c = in_c;
      q.wait_empty = 1'b0;
      expected_dists.insert(expected_dists.size(), predict_dist(q));
    end
    if (rst_n && out_valid && !out_stall) begin
      if (expected_dists.size() == 0) begin
        report_mismatch("result with no query pending");
      end else begin
        e = expected_dists.pop_front();
        if (out_sq_distance !== e.sq_distance)
          report_mismatch($sformatf("sq_distance %h, expected %h", out_sq_distance,
                                    e.sq_distance));
        if (out_saturated !== e.saturated)
          report_mismatch($sformatf("saturated %b, expected %b", out_saturated, e.saturated));
        if (out_degenerate !== e.degenerate)
          report_mismatch($sformatf("degenerate %b, expected %b", out_degenerate,
                                    e.degenerate));
      end
    end
  end

  task automatic add_query(logic signed [31:0] v0x, v0y, v0z, v1x, v1y, v1z,
                           v2x, v2y, v2z, px, py, pz);
    query_t q;
    q.c = '{v0x, v0y, v0z, v1x, v1y, v1z, v2x, v2y, v2z, px, py, pz};
    q.wait_empty = 1'b0;
    pending_queries.insert(pending_queries.size(), q);
  endtask

  function automatic logic signed [31:0] rand_coord(int kind);
    case (kind)
      0: return $signed($urandom);
      1: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
      default: return $signed($urandom_range(32'h0400_0000)) - 32'sh0200_0000;
    endcase
  endfunction

  initial begin
    localparam logic signed [31:0] U = 32'sh0001_0000;
    localparam logic signed [31:0] H = 32'sh0000_8000;
    localparam logic signed [31:0] MX = 32'sh7fff_ffff;
    localparam logic signed [31:0] MN = -32'sh7fff_ffff - 1;
    query_t q;
    int kind;
    // Unit right triangle in the z = 0 plane, the point visiting every region.
    add_query(0, 0, 0, U, 0, 0, 0, U, 0, H / 2, H / 2, U);
    add_query(0, 0, 0, U, 0, 0, 0, U, 0, -U, -U, 0);
    add_query(0, 0, 0, U, 0, 0, 0, U, 0, 2 * U, -U, H);
    add_query(0, 0, 0, U, 0, 0, 0, U, 0, -U, 2 * U, 0);
    add_query(0, 0, 0, U, 0, 0, 0, U, 0, H, -U, 0);
    add_query(0, 0, 0, U, 0, 0, 0, U, 0, -U, H, -U);
    add_query(0, 0, 0, U, 0, 0, 0, U, 0, U, U, 0);
    add_query(0, 0, 0, U, 0, 0, 0, U, 0, 2 * U, 3 * U, 0);
    add_query(0, 0, 0, U, 0, 0, 0, U, 0, 3 * U, 2 * U, 0);
    add_query(0, 0, 0, U, 0, 0, 0, U, 0, 0, 0, 0);
    add_query(0, 0, 0, U, 0, 0, 0, U, 0, 1, 1, 1);
    // Collapsed triangles: a single point and a segment.
    add_query(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    add_query(U, U, U, U, U, U, U, U, U, 0, 0, 0);
    add_query(0, 0, 0, U, U, U, 2 * U, 2 * U, 2 * U, U, 0, 0);
    add_query(0, 0, 0, U, 0, 0, 2 * U, 0, 0, U, U, 0);
    // Coordinate extremes, where the result can saturate.
    add_query(MX, MX, MX, MX, MX, MX, MX, MX, MX, MN, MN, MN);
    add_query(MN, MN, MN, MX, MN, MN, MN, MX, MN, MX, MX, MX);
    add_query(MX, MN, MX, MN, MX, MN, MX, MX, MN, MN, MN, MX);
    add_query(MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN, MN);
    add_query(MX, 0, 0, 0, MX, 0, 0, 0, MX, 0, 0, 0);
    add_query(-1, -1, -1, 0, -1, -1, -1, 0, -1, -1, -1, 0);
    for (int n = 0; n < 400; n++) begin
      kind = $urandom_range(9);
      for (int i = 0; i < 12; i++)
        q.c[i] = rand_coord(kind < 2 ? 0 : kind < 7 ? 1 : 2);
      if (kind == 9) begin
        // Vertices in a line, so the Gram determinant is zero.
        for (int i = 0; i < 3; i++) q.c[6 + i] = 2 * q.c[3 + i] - q.c[i];
        if ($urandom_range(1)) for (int i = 0; i < 3; i++) q.c[9 + i] = q.c[3 + i];
      end
      q.wait_empty = (n == 180);
      pending_queries.insert(pending_queries.size(), q);
    end
    all_queued = 1'b1;
  end

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    wait (all_queued);
    while (pending_queries.size() > 0 || expected_dists.size() > 0 || in_valid)
      @(posedge clk);
    repeat (100) @(posedge clk);
    if (n_errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("simulation failed");
    $finish;
  end
endmodule

@@ filelist.f @@
src/pts_pkg.sv
src/pts_gram.sv
src/pts_solve.sv
src/pts_div.sv
src/pts_eval.sv
src/point_triangle_sq_distance_top.sv
tb/sv/tb.sv
